>>> rtl/core/rkpb_pkg.sv
// ----------------------------------------------------------------------------
// rkpb_pkg
// Shared types and constants for the rotary knob position and button block.
// ----------------------------------------------------------------------------
`default_nettype none

package rkpb_pkg;

  localparam int unsigned SettleW   = 24;
  localparam int unsigned LockoutW  = 24;
  localparam int unsigned RotationW = 16;
  localparam int unsigned AngleW    = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 24;

  localparam logic [SettleW-1:0]   SettleReset   = SettleW'(50000);
  localparam logic [LockoutW-1:0]  LockoutReset  = LockoutW'(1000);
  localparam logic [RotationW-1:0] RotationReset = RotationW'(360);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SETTLE   = 2'd0,
    CFG_LOCKOUT  = 2'd1,
    CFG_ROTATION = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic button_level;
    logic enc_a;
    logic enc_b;
  } in_item_t;

  typedef struct packed {
    logic [AngleW-1:0] angle;
    logic              button_held;
    logic              press_event;
  } out_item_t;

  // one configuration write as seen by the datapath modules
  typedef struct packed {
    logic                en;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [SettleW-1:0]   settle;
    logic [LockoutW-1:0]  lockout;
    logic [RotationW-1:0] rotation;
  } cfg_regs_t;

endpackage

`default_nettype wire

>>> rtl/core/rkpb_cfg.sv
// ----------------------------------------------------------------------------
// rkpb_cfg
// Configuration register file: settle time, edge lockout and full rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module rkpb_cfg (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  rkpb_pkg::cfg_wr_t   cfg_wr_i,
  output rkpb_pkg::cfg_regs_t regs_o
);
  import rkpb_pkg::*;

  cfg_regs_t regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.settle   <= SettleReset;
      regs_q.lockout  <= LockoutReset;
      regs_q.rotation <= RotationReset;
    end else if (cfg_wr_i.en) begin
      unique case (cfg_idx_e'(cfg_wr_i.idx))
        CFG_SETTLE:   regs_q.settle   <= cfg_wr_i.data[SettleW-1:0];
        CFG_LOCKOUT:  regs_q.lockout  <= cfg_wr_i.data[LockoutW-1:0];
        CFG_ROTATION: regs_q.rotation <= cfg_wr_i.data[RotationW-1:0];
        default: ;
      endcase
    end
  end

  assign regs_o = regs_q;

endmodule

`default_nettype wire

>>> rtl/core/rkpb_encoder.sv
// ----------------------------------------------------------------------------
// rkpb_encoder
// Quadrature line A edge detect with lockout counter and wrapping position.
// ----------------------------------------------------------------------------
`default_nettype none

module rkpb_encoder #(
  parameter int unsigned COUNT_WIDTH    = 24,
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                step_i,
  input  wire                                enc_a_i,
  input  wire                                enc_b_i,
  input  wire  [rkpb_pkg::LockoutW-1:0]      lockout_i,
  input  wire  [rkpb_pkg::RotationW-1:0]     rotation_i,
  input  rkpb_pkg::cfg_wr_t                  cfg_wr_i,
  output logic [POSITION_WIDTH-1:0]          position_o
);
  import rkpb_pkg::*;

  localparam int unsigned CmpW = (COUNT_WIDTH > LockoutW) ? COUNT_WIDTH : LockoutW;
  localparam int unsigned ModW = POSITION_WIDTH + 1;
  localparam int unsigned ExtW = RotationW + 1;
  localparam logic [ExtW-1:0] Span = ExtW'(1) << POSITION_WIDTH;

  logic                      prev_a_q;
  logic [COUNT_WIDTH-1:0]    cnt_q, cnt_d, elapsed;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d, pos_step;
  logic [ModW-1:0]           mod_cur, mod_new, pos_inc;
  logic                      edge_ok;

  // effective modulus: full rotation clipped to the position span
  function automatic logic [ModW-1:0] clip_mod(input logic [RotationW-1:0] rot);
    logic [ExtW-1:0] ext;
    logic [ExtW-1:0] m;
    ext = ExtW'(rot);
    m   = (ext > Span) ? Span : ext;
    return m[ModW-1:0];
  endfunction

  assign mod_cur = clip_mod(rotation_i);
  assign mod_new = clip_mod(cfg_wr_i.data[RotationW-1:0]);
  assign elapsed = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
  assign edge_ok = enc_a_i && !prev_a_q && (CmpW'(elapsed) >= CmpW'(lockout_i));
  assign pos_inc = ModW'(pos_q) + 1'b1;

  always_comb begin
    if (mod_cur < ModW'(2)) begin
      pos_step = '0;
    end else if (enc_b_i) begin
      pos_step = (pos_inc >= mod_cur) ? '0 : pos_inc[POSITION_WIDTH-1:0];
    end else if (pos_q == '0 || ModW'(pos_q) >= mod_cur) begin
      pos_step = POSITION_WIDTH'(mod_cur - 1'b1);
    end else begin
      pos_step = pos_q - 1'b1;
    end
  end

  always_comb begin
    pos_d = pos_q;
    cnt_d = cnt_q;
    if (step_i) begin
      cnt_d = edge_ok ? '0 : elapsed;
      if (edge_ok) begin
        pos_d = pos_step;
      end
    end else if (cfg_wr_i.en && cfg_idx_e'(cfg_wr_i.idx) == CFG_ROTATION &&
                 ModW'(pos_q) >= mod_new) begin
      // shrinking turn pulls the position back to zero
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a_q <= 1'b1;
      cnt_q    <= '1;
      pos_q    <= '0;
    end else begin
      if (step_i) begin
        prev_a_q <= enc_a_i;
      end
      cnt_q <= cnt_d;
      pos_q <= pos_d;
    end
  end

  assign position_o = pos_q;

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_cur >= ModW'(2)) ? (ModW'(pos_q) < mod_cur) : (pos_q == '0))
    else $error("position outside the turn");

  a_edge_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && edge_ok) |=> (cnt_q == '0))
    else $error("accepted edge did not restart the lockout count");

  a_idle_holds_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!step_i && !cfg_wr_i.en) |=> $stable(pos_q))
    else $error("position moved without a transaction");

endmodule

`default_nettype wire

>>> rtl/core/rkpb_debounce.sv
// ----------------------------------------------------------------------------
// rkpb_debounce
// Push button settle counter, debounced pressed state and press pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module rkpb_debounce #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           step_i,
  input  wire                           button_level_i,
  input  wire  [rkpb_pkg::SettleW-1:0]  settle_i,
  output logic                          held_o,
  output logic                          press_o
);
  import rkpb_pkg::*;

  localparam int unsigned CmpW = (COUNT_WIDTH > SettleW) ? COUNT_WIDTH : SettleW;

  logic                   last_q;
  logic                   held_q, held_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   press;

  always_comb begin
    cnt_d  = (button_level_i != last_q) ? '0 :
             ((cnt_q == '1) ? cnt_q : cnt_q + 1'b1);
    held_d = held_q;
    press  = 1'b0;
    if (CmpW'(cnt_d) > CmpW'(settle_i)) begin
      if (!held_q && !button_level_i) begin
        held_d = 1'b1;
        press  = 1'b1;
      end else if (held_q && button_level_i) begin
        held_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b1;
      cnt_q  <= '0;
      held_q <= 1'b0;
    end else if (step_i) begin
      last_q <= button_level_i;
      cnt_q  <= cnt_d;
      held_q <= held_d;
    end
  end

  // results of the current transaction, taken into the output register
  assign held_o  = held_d;
  assign press_o = press;

  a_press_rises_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && press) |=> (held_q && !$past(held_q)))
    else $error("press pulse without a new debounced press");

endmodule

`default_nettype wire

>>> rtl/core/rotary_knob_position_and_button_top.sv
// ----------------------------------------------------------------------------
// rotary_knob_position_and_button_top
// Rotary encoder position with edge lockout and debounced push button.
// ----------------------------------------------------------------------------
// Results are registered and appear in the cycle after their input transaction.
// Throughput: one transaction per cycle; the output register frees itself
//   in the same cycle its result is taken, so the input stalls only while a
//   result sits unread.
// Reset: asynchronous, clears all state and loads the register defaults.
`default_nettype none

module rotary_knob_position_and_button_top #(
  parameter int unsigned COUNT_WIDTH    = 24,
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  rkpb_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output rkpb_pkg::out_item_t              out_data_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [rkpb_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire  [rkpb_pkg::CfgDataW-1:0]    cfg_data_i
);
  import rkpb_pkg::*;

  cfg_wr_t                   cfg_wr;
  cfg_regs_t                 regs;
  logic                      step;
  logic [POSITION_WIDTH-1:0] position;
  logic                      held, press;
  logic                      out_valid_q;
  logic                      out_held_q;
  logic                      out_press_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr.en   = cfg_valid_i;
  assign cfg_wr.idx  = cfg_idx_i;
  assign cfg_wr.data = cfg_data_i;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign step       = in_valid_i && !in_stall_o;

  rkpb_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_wr_i (cfg_wr),
    .regs_o   (regs)
  );

  rkpb_encoder #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_encoder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .enc_a_i    (in_data_i.enc_a),
    .enc_b_i    (in_data_i.enc_b),
    .lockout_i  (regs.lockout),
    .rotation_i (regs.rotation),
    .cfg_wr_i   (cfg_wr),
    .position_o (position)
  );

  rkpb_debounce #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_debounce (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .button_level_i (in_data_i.button_level),
    .settle_i       (regs.settle),
    .held_o         (held),
    .press_o        (press)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_held_q  <= 1'b0;
      out_press_q <= 1'b0;
    end else if (step) begin
      out_held_q  <= held;
      out_press_q <= press;
    end
  end

  // angle is the live position, which already holds this transaction's update
  always_comb begin
    out_data_o.angle       = AngleW'(position);
    out_data_o.button_held = out_held_q;
    out_data_o.press_event = out_press_q;
  end

  assign out_valid_o = out_valid_q;

  a_result_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("transaction produced no result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!step && (!out_valid_q || !out_stall_i)) |=> !out_valid_q)
    else $error("result without a transaction");

  a_press_implies_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_press_q) |-> out_held_q)
    else $error("press event reported while button not held");

endmodule

`default_nettype wire

>>> tb/sv/tb_rotary_knob_position_and_button_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotary_knob_position_and_button_top
// Self-checking bench for the knob block. A short table of directed ticks
// covers lockout, wrap both ways, small and shrinking turns, an ignored
// register index and an unreachable settle time. Random quadrature and
// button traffic with bounce and noise follows under several register
// settings and idling phases. Typed directed rows are checked against table
// values, all others against a cycle-free model of encoder and debounce logic.
// ----------------------------------------------------------------------------
module tb_rotary_knob_position_and_button_top;
  import rkpb_pkg::*;

  localparam int unsigned CountW = 24;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;  // decodes to no register
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SegItems = 250;
  localparam int unsigned SegCount = 6;

  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    in_item_t            smp;
    logic                typed;
    out_item_t           want;
  } step_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  int unsigned cycle_cnt = 0;
  int          err_cnt = 0;

  out_item_t reports_due[$];
  step_row_t dir_rows[$];

  // knob model state and registers
  logic [SettleW-1:0]   settle_cfg;
  logic [LockoutW-1:0]  lockout_cfg;
  logic [RotationW-1:0] turn_cfg;
  logic                 enc_a_d;
  logic [CountW-1:0]    edge_age;
  logic [AngleW-1:0]    angle_q;
  logic                 btn_d;
  logic [CountW-1:0]    btn_age;
  logic                 held_q;

  rotary_knob_position_and_button_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [CountW-1:0] sat_up(input logic [CountW-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  task automatic knob_reset();
    settle_cfg  = SettleReset;
    lockout_cfg = LockoutReset;
    turn_cfg    = RotationReset;
    enc_a_d     = 1'b1;
    edge_age    = CountMax;
    angle_q     = '0;
    btn_d       = 1'b1;
    btn_age     = '0;
    held_q      = 1'b0;
  endtask

  task automatic load_knob_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (idx)
      CFG_SETTLE:  settle_cfg = data[SettleW-1:0];
      CFG_LOCKOUT: lockout_cfg = data[LockoutW-1:0];
      CFG_ROTATION: begin
        turn_cfg = data[RotationW-1:0];
        if (angle_q >= turn_cfg) angle_q = '0;
      end
      default: ;
    endcase
  endtask

  task automatic knob_step(input in_item_t smp, output out_item_t rpt);
    logic [CountW-1:0] elapsed;
    logic              press;
    elapsed = sat_up(edge_age);
    press = 1'b0;
    // encoder first, so a press reports the updated angle
    if (smp.enc_a && !enc_a_d && elapsed >= lockout_cfg) begin
      edge_age = '0;
      if (turn_cfg < 2) begin
        angle_q = '0;
      end else if (smp.enc_b) begin
        angle_q = ({1'b0, angle_q} + 17'd1 >= {1'b0, turn_cfg}) ? '0 : angle_q + 1'b1;
      end else begin
        angle_q = (angle_q == '0 || angle_q >= turn_cfg) ? turn_cfg - 1'b1 : angle_q - 1'b1;
      end
    end else begin
      edge_age = elapsed;
    end
    enc_a_d = smp.enc_a;

    if (smp.button_level != btn_d) btn_age = '0;
    else btn_age = sat_up(btn_age);
    if (btn_age > settle_cfg) begin
      if (!held_q && !smp.button_level) begin
        held_q = 1'b1;
        press = 1'b1;
      end else if (held_q && smp.button_level) begin
        held_q = 1'b0;
      end
    end
    btn_d = smp.button_level;

    rpt.angle = angle_q;
    rpt.button_held = held_q;
    rpt.press_event = press;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_sample(input in_item_t smp, input logic typed, input out_item_t want);
    out_item_t rpt;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = smp;
    do @(posedge clk); while (in_stall);
    knob_step(smp, rpt);
    reports_due.push_back(typed ? want : rpt);
    @(negedge clk);
  endtask

  // registers change only with nothing in flight
  task automatic program_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    in_valid = 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    load_knob_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic dir_item(input logic btn, input logic a, input logic b, input logic typed,
                          input int unsigned angle, input logic held, input logic press);
    step_row_t row;
    row = '0;
    row.smp.button_level = btn;
    row.smp.enc_a = a;
    row.smp.enc_b = b;
    row.typed = typed;
    row.want.angle = AngleW'(angle);
    row.want.button_held = held;
    row.want.press_event = press;
    dir_rows.push_back(row);
  endtask

  task automatic dir_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    step_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    dir_rows.push_back(row);
  endtask

  // mostly well-formed turning and pressing, with bounce and wrong-phase noise
  task automatic run_turns(input int unsigned n);
    in_item_t    smp;
    logic        btn_lvl;
    logic        a_lvl;
    logic        turn_up;
    int unsigned r;
    btn_lvl = 1'b1;
    a_lvl = 1'b0;
    turn_up = 1'($urandom_range(0, 1));
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) btn_lvl = ~btn_lvl;
      smp.button_level = (r >= 6 && r < 9) ? ~btn_lvl : btn_lvl;
      if ($urandom_range(0, 99) < 4) turn_up = ~turn_up;
      if ($urandom_range(0, 99) < 40) a_lvl = ~a_lvl;
      smp.enc_a = a_lvl;
      smp.enc_b = ($urandom_range(0, 99) < 10) ? ~turn_up : turn_up;
      send_sample(smp, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < rcv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_rotary_knob_position_and_button_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin : check_reports
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected transaction, expected none, got angle %0d held %0b press %0b",
                 $time, out_data.angle, out_data.button_held, out_data.press_event);
      end else begin
        want = reports_due.pop_front();
        if (out_data.angle !== want.angle) begin
          err_cnt++;
          $display("%0t: angle expected %0d got %0d", $time, want.angle, out_data.angle);
        end
        if (out_data.button_held !== want.button_held) begin
          err_cnt++;
          $display("%0t: button_held expected %0b got %0b", $time, want.button_held,
                   out_data.button_held);
        end
        if (out_data.press_event !== want.press_event) begin
          err_cnt++;
          $display("%0t: press_event expected %0b got %0b", $time, want.press_event,
                   out_data.press_event);
        end
      end
    end
  end

  initial begin : main
    step_row_t           row;
    logic [SettleW-1:0]  st;
    logic [LockoutW-1:0] lk;
    logic [15:0]         rt;
    logic [7:0]          hi;

    knob_reset();

    // reset registers: lockout 1000, settle 50000, turn 360
    dir_item(1, 1, 0, 1, 0, 0, 0);
    dir_item(1, 0, 1, 1, 0, 0, 0);
    dir_item(1, 1, 1, 1, 1, 0, 0);        // first edge passes, counter saturated
    dir_item(1, 0, 0, 0, 0, 0, 0);
    dir_item(1, 1, 0, 1, 1, 0, 0);        // inside lockout
    dir_item(0, 0, 0, 0, 0, 0, 0);
    dir_reg(CFG_SETTLE, 24'd0);
    dir_reg(CFG_LOCKOUT, 24'd0);
    dir_item(0, 1, 0, 1, 0, 1, 1);        // step down and press on one tick
    dir_item(0, 0, 0, 0, 0, 0, 0);
    dir_item(0, 1, 0, 1, 359, 1, 0);      // wrap below zero
    dir_item(1, 0, 1, 0, 0, 0, 0);
    dir_item(1, 1, 1, 1, 0, 0, 0);        // wrap at the top, release
    dir_reg(CFG_ROTATION, 24'hFF_FFFF);   // upper bits masked off
    dir_item(1, 0, 0, 0, 0, 0, 0);
    dir_item(1, 1, 0, 1, 65534, 0, 0);
    dir_reg(CFG_ROTATION, 24'hAB_0064);   // shrink below current angle
    dir_item(1, 0, 1, 1, 0, 0, 0);
    dir_item(1, 1, 1, 0, 0, 0, 0);
    dir_reg(CFG_ROTATION, 24'd1);
    dir_item(1, 0, 1, 0, 0, 0, 0);
    dir_item(1, 1, 1, 1, 0, 0, 0);        // degenerate turn holds zero
    dir_reg(CFG_ROTATION, 24'd0);
    dir_item(1, 0, 0, 0, 0, 0, 0);
    dir_item(1, 1, 0, 1, 0, 0, 0);
    dir_reg(CFG_ROTATION, 24'd360);
    dir_reg(CfgIdxSpare, 24'hFF_FFFF);
    dir_reg(CFG_SETTLE, 24'hFF_FFFF);     // button can never settle
    dir_item(0, 0, 1, 0, 0, 0, 0);
    dir_item(0, 1, 1, 1, 1, 0, 0);
    dir_reg(CFG_LOCKOUT, 24'hFF_FFFF);
    dir_item(0, 0, 1, 0, 0, 0, 0);
    dir_item(0, 1, 1, 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < dir_rows.size(); i++) begin
      row = dir_rows[i];
      if (row.is_cfg) program_reg(row.idx, row.data);
      else send_sample(row.smp, row.typed, row.want);
    end

    for (int unsigned seg = 0; seg < SegCount; seg++) begin
      hi = 8'($urandom_range(0, 255));
      case (seg)
        0: begin st = '0; lk = '0; rt = 16'd2; end
        1: begin
          st = SettleW'($urandom_range(1, 6));
          lk = LockoutW'($urandom_range(1, 4));
          rt = 16'($urandom_range(3, 12));
        end
        2: begin
          st = SettleW'($urandom_range(0, 12));
          lk = LockoutW'($urandom_range(0, 8));
          rt = 16'hFFFF;
        end
        3: begin
          st = 24'hFF_FFFE;
          lk = LockoutW'($urandom_range(0, 3));
          rt = 16'($urandom_range(2, 65535));
        end
        4: begin st = 24'd2; lk = 24'd16; rt = 16'd360; end
        default: begin
          st = SettleW'($urandom_range(0, 20));
          lk = LockoutW'($urandom_range(0, 10));
          rt = 16'($urandom_range(2, 40));
        end
      endcase
      program_reg(CFG_SETTLE, st);
      program_reg(CFG_LOCKOUT, lk);
      program_reg(CFG_ROTATION, {hi, rt});

      case (seg % 4)
        1: begin snd_idle_pct = 48; rcv_stall_pct = 0; end
        2: begin snd_idle_pct = 0; rcv_stall_pct = 48; end
        3: begin snd_idle_pct = 26; rcv_stall_pct = 26; end
        default: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
      endcase
      run_turns(SegItems);
    end

    in_valid = 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_rotary_knob_position_and_button_top: done, clean");
    end else begin
      $display("tb_rotary_knob_position_and_button_top: done, errors");
    end
    $finish;
  end

endmodule

>>> rotary_knob_position_and_button_top.f
rtl/core/rkpb_pkg.sv
rtl/core/rkpb_cfg.sv
rtl/core/rkpb_encoder.sv
rtl/core/rkpb_debounce.sv
rtl/core/rotary_knob_position_and_button_top.sv
tb/sv/tb_rotary_knob_position_and_button_top.sv
